FILE: rtl/key_frequency_table_top_macros.svh
// ----------------------------------------------------------------------------
// key_frequency_table_top_macros: assertion macros
// Implication checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef KEY_FREQUENCY_TABLE_TOP_MACROS_SVH
`define KEY_FREQUENCY_TABLE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define KFT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("key_frequency_table: same-cycle check failed");
// next-cycle implication
`define KFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("key_frequency_table: next-cycle check failed");
`else
`define KFT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define KFT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/kft_pkg.sv
// ----------------------------------------------------------------------------
// kft_pkg
// Sizes, types and helpers shared by the key frequency table.
// ----------------------------------------------------------------------------
package kft_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int COUNT_BITS    = 16;
  localparam int KEY_W         = 30;

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);
  localparam int WORD_W = KEY_W + COUNT_BITS;

  // result port widths
  localparam int ENTRY_INDEX_W  = 10;
  localparam int HIT_COUNT_W    = 16;
  localparam int ENTRIES_USED_W = 11;

  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
  } mem_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]      idx;
    logic [COUNT_BITS-1:0] cnt;
    logic                  was_new;
    logic                  was_dropped;
    logic [FILL_W-1:0]     used;
  } res_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] cnt);
    sat_inc = (cnt == {COUNT_BITS{1'b1}}) ? cnt : cnt + COUNT_BITS'(1);
  endfunction

endpackage

FILE: rtl/key_frequency_table_top.sv
// On an empty table the key is appended at once; else entries in use are
// compared in order, one per cycle on the single RAM read port, until a
// match or the last entry. start is ignored while busy; busy drops as the
// result strobes; results cannot stall.
// Reset (rst_n low, synchronous) empties the table by clearing the fill
// count; the RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// key_frequency_table_top
// Distinct key frequency counter over a first-arrival ordered table.
// ----------------------------------------------------------------------------
`include "key_frequency_table_top_macros.svh"

module key_frequency_table_top
  import kft_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [KEY_W-1:0]          in_phone_key,
  output logic                      out_valid,
  output logic [ENTRY_INDEX_W-1:0]  out_entry_index,
  output logic [HIT_COUNT_W-1:0]    out_hit_count,
  output logic                      out_was_new,
  output logic                      out_was_dropped,
  output logic [ENTRIES_USED_W-1:0] out_entries_used
);

  mem_req_t          mem_req;
  logic [WORD_W-1:0] rd_data;
  logic              res_valid;
  res_t              res;

  kft_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .key       (in_phone_key),
    .busy      (busy),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res       (res)
  );

  kft_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (rd_data)
  );

  assign out_valid        = res_valid;
  assign out_entry_index  = ENTRY_INDEX_W'(res.idx);
  assign out_hit_count    = HIT_COUNT_W'(res.cnt);
  assign out_was_new      = res.was_new;
  assign out_was_dropped  = res.was_dropped;
  assign out_entries_used = ENTRIES_USED_W'(res.used);

  `KFT_ASSERT_NEXT(a_accept_progress, clk, rst_n, start && !busy, busy || out_valid)
  `KFT_ASSERT_NOW(a_new_xor_drop, clk, rst_n, out_valid, !(out_was_new && out_was_dropped))
  `KFT_ASSERT_NOW(a_drop_only_full, clk, rst_n, out_valid && out_was_dropped, out_entries_used == ENTRIES_USED_W'(TABLE_ENTRIES) && out_hit_count == '0)
  `KFT_ASSERT_NOW(a_new_count_one, clk, rst_n, out_valid && out_was_new, out_hit_count == HIT_COUNT_W'(1))

endmodule

FILE: rtl/kft_ram.sv
// ----------------------------------------------------------------------------
// kft_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/kft_ctrl.sv
// ----------------------------------------------------------------------------
// kft_ctrl
// Scan sequencer: walks the entries in use, one read per cycle, and
// updates the matched entry or appends the new key, or drops it if full.
// ----------------------------------------------------------------------------
module kft_ctrl
  import kft_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [KEY_W-1:0]  key,
  output logic              busy,
  output mem_req_t          mem_req,
  input  logic [WORD_W-1:0] rd_data,
  output logic              res_valid,
  output res_t              res
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                  state_r, state_nxt;
  logic [IDX_W-1:0]      ptr_r, ptr_nxt;
  logic [FILL_W-1:0]     fill_r, fill_nxt;
  logic [KEY_W-1:0]      key_r, key_nxt;
  logic                  res_valid_r, res_valid_nxt;
  res_t                  res_r, res_nxt;

  logic [KEY_W-1:0]      rd_key;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [COUNT_BITS-1:0] inc_cnt;
  logic                  last;
  logic                  full;

  assign rd_key  = rd_data[WORD_W-1:COUNT_BITS];
  assign rd_cnt  = rd_data[COUNT_BITS-1:0];
  assign inc_cnt = sat_inc(rd_cnt);
  assign last    = ({1'b0, ptr_r} + FILL_W'(1)) == fill_r;
  assign full    = fill_r == FILL_W'(TABLE_ENTRIES);

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    fill_nxt      = fill_r;
    key_nxt       = key_r;
    res_valid_nxt = 1'b0;
    res_nxt       = res_r;
    mem_req       = '0;
    mem_req.rd_addr = ptr_r + IDX_W'(1);

    case (state_r)
      S_IDLE: begin
        if (start) begin
          key_nxt = key;
          if (fill_r == '0) begin
            // empty table: append at once
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = '0;
            mem_req.wr_data = {key, COUNT_BITS'(1)};
            res_valid_nxt   = 1'b1;
            res_nxt         = '{idx: '0, cnt: COUNT_BITS'(1), was_new: 1'b1,
                                was_dropped: 1'b0, used: FILL_W'(1)};
            fill_nxt        = FILL_W'(1);
          end else begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = '0;
            ptr_nxt         = '0;
            state_nxt       = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (rd_key == key_r) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = ptr_r;
          mem_req.wr_data = {key_r, inc_cnt};
          res_valid_nxt   = 1'b1;
          res_nxt         = '{idx: ptr_r, cnt: inc_cnt, was_new: 1'b0,
                              was_dropped: 1'b0, used: fill_r};
          state_nxt       = S_IDLE;
        end else if (last) begin
          res_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (full) begin
            res_nxt = '{idx: '0, cnt: '0, was_new: 1'b0,
                        was_dropped: 1'b1, used: fill_r};
          end else begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = fill_r[IDX_W-1:0];
            mem_req.wr_data = {key_r, COUNT_BITS'(1)};
            fill_nxt        = fill_r + FILL_W'(1);
            res_nxt         = '{idx: fill_r[IDX_W-1:0], cnt: COUNT_BITS'(1),
                                was_new: 1'b1, was_dropped: 1'b0,
                                used: fill_r + FILL_W'(1)};
          end
        end else begin
          // advance to the entry whose read is already in flight
          mem_req.rd_en = 1'b1;
          ptr_nxt       = ptr_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    key_r <= key_nxt;
    res_r <= res_nxt;
  end

  assign busy      = state_r == S_SCAN;
  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule
